@@ rtl/mmme_pkg.sv @@
// ----------------------------------------------------------------------------
// mmme_pkg
// Shared widths, limits and controller/datapath command and status types
// for the mean / median / mode engine.
// ----------------------------------------------------------------------------
package mmme_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 4096;

  localparam int unsigned VAL_W     = 14;
  localparam int unsigned MEAN_W    = 17;
  localparam int unsigned MEDIAN_W  = 15;
  localparam int unsigned CNT_OUT_W = 13;

  localparam logic [VAL_W-1:0]  VAL_MAX  = {VAL_W{1'b1}};
  localparam logic [MEAN_W-1:0] MEAN_SAT = {MEAN_W{1'b1}};

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic idx_zero;
    logic h_wr_inc;
    logic scan_rd;
    logic div_init;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic idx_end;
    logic h_done;
    logic div_last;
  } sts_t;

endpackage

@@ rtl/mean_median_mode_engine_top.sv @@
// ----------------------------------------------------------------------------
// mean_median_mode_engine_top
// Collects samples, then reports mean in tenths, twice the median, the mode,
// the kept count and an overflow flag for the set.
//
//   channel | ports                                   | handshake
//   input   | in_sample, in_last                      | start && !busy
//   result  | out_mean_tenths .. out_overflowed       | out_valid, one cycle
//
// A non-final item is stored and the engine stays idle for the next. The
// final item adds a histogram build per kept item (store read, histogram
// read, histogram write), a value scan over the histogram port plus a
// drain state, bit-serial division and a result state. After reset a clear
// of all 16384 histogram entries runs with busy high. The receiver cannot
// stall; out_valid lasts one cycle.
// ----------------------------------------------------------------------------
module mean_median_mode_engine_top #(
  parameter int unsigned MAX_ITEMS = mmme_pkg::MAX_ITEMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [mmme_pkg::VAL_W-1:0]     in_sample,
  input  logic                           in_last,
  output logic                           out_valid,
  output logic [mmme_pkg::MEAN_W-1:0]    out_mean_tenths,
  output logic [mmme_pkg::MEDIAN_W-1:0]  out_median_doubled,
  output logic [mmme_pkg::VAL_W-1:0]     out_mode_value,
  output logic [mmme_pkg::CNT_OUT_W-1:0] out_element_count,
  output logic                           out_overflowed
);

  mmme_pkg::cmd_t cmd;
  mmme_pkg::sts_t sts;

  mmme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_last   (in_last),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mmme_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_sample          (in_sample),
    .sts                (sts),
    .out_mean_tenths    (out_mean_tenths),
    .out_median_doubled (out_median_doubled),
    .out_mode_value     (out_mode_value),
    .out_element_count  (out_element_count),
    .out_overflowed     (out_overflowed)
  );

endmodule

@@ rtl/mmme_ctrl.sv @@
// ----------------------------------------------------------------------------
// mmme_ctrl
// Sequencer: clear pass, load, histogram build, value scan, mean division
// and result strobe.
// ----------------------------------------------------------------------------
module mmme_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_last,
  input  mmme_pkg::sts_t sts,
  output mmme_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_H1, ST_H2, ST_H3, ST_SCAN, ST_DRAIN, ST_DIV, ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.idx_end) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.idx_zero = 1'b1;
            state_nxt    = ST_H1;
          end
        end
      end
      ST_H1: state_nxt = ST_H2;
      ST_H2: state_nxt = ST_H3;
      ST_H3: begin
        cmd.h_wr_inc = 1'b1;
        state_nxt    = sts.h_done ? ST_SCAN : ST_H1;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.idx_end) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

endmodule

@@ rtl/mmme_dp.sv @@
// ----------------------------------------------------------------------------
// mmme_dp
// Sample store, value histogram, running sum and count, order statistic and
// mode scan, and a restoring divider for the mean.
// ----------------------------------------------------------------------------
module mmme_dp #(
  parameter int unsigned MAX_ITEMS = mmme_pkg::MAX_ITEMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mmme_pkg::cmd_t                 cmd,
  input  logic [mmme_pkg::VAL_W-1:0]     in_sample,
  output mmme_pkg::sts_t                 sts,
  output logic [mmme_pkg::MEAN_W-1:0]    out_mean_tenths,
  output logic [mmme_pkg::MEDIAN_W-1:0]  out_median_doubled,
  output logic [mmme_pkg::VAL_W-1:0]     out_mode_value,
  output logic [mmme_pkg::CNT_OUT_W-1:0] out_element_count,
  output logic                           out_overflowed
);

  localparam int unsigned VW     = mmme_pkg::VAL_W;
  localparam int unsigned ADDR_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SUM_W  = VW + CNT_W;
  localparam int unsigned NUM_W  = SUM_W + 5;
  localparam int unsigned DEN_W  = CNT_W + 1;
  localparam int unsigned DC_W   = $clog2(NUM_W);
  localparam int unsigned VDEPTH = 1 << VW;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

  logic [VW-1:0]    store_mem [MAX_ITEMS];
  logic [CNT_W-1:0] hist_mem  [VDEPTH];

  logic [CNT_W-1:0]  count_r;
  logic [SUM_W-1:0]  sum_r;
  logic              ovf_r;
  logic [ADDR_W-1:0] sidx_r;
  logic [VW-1:0]     vidx_r;
  logic [VW-1:0]     vd_r;
  logic              scan_vld_r;
  logic [DC_W-1:0]   dcnt_r;

  logic [VW-1:0]     samp_rd_r;
  logic [CNT_W-1:0]  hist_rd_r;
  logic [CNT_W-1:0]  seen_r, best_r;
  logic [VW-1:0]     lo_r, hi_r, mode_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  rem_r;

  logic              hist_we;
  logic [VW-1:0]     hist_wa, hist_ra;
  logic [CNT_W-1:0]  hist_wd;
  logic [CNT_W-1:0]  seen_nxt, ka, kb;
  logic [DEN_W-1:0]  den;
  logic [DEN_W:0]    trial;
  logic              ge;

  always_comb begin
    hist_we = 1'b0;
    hist_wa = vidx_r;
    hist_wd = '0;
    if (cmd.clr_wr) begin
      hist_we = 1'b1;
    end else if (cmd.h_wr_inc) begin
      hist_we = 1'b1;
      hist_wa = samp_rd_r;
      hist_wd = hist_rd_r + CNT_W'(1);
    end else if (scan_vld_r) begin
      hist_we = 1'b1;
      hist_wa = vd_r;
    end
  end

  assign hist_ra = cmd.scan_rd ? vidx_r : samp_rd_r;

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    hist_rd_r <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (count_r < CNT_MAX)) store_mem[count_r[ADDR_W-1:0]] <= in_sample;
    samp_rd_r <= store_mem[sidx_r];
  end

  assign seen_nxt = seen_r + hist_rd_r;
  assign ka       = (count_r - CNT_W'(1)) >> 1;
  assign kb       = count_r >> 1;
  assign den      = {count_r, 1'b0};
  assign trial    = {rem_r, num_r[NUM_W-1]};
  assign ge       = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      sum_r      <= '0;
      ovf_r      <= 1'b0;
      sidx_r     <= '0;
      vidx_r     <= '0;
      scan_vld_r <= 1'b0;
      dcnt_r     <= '0;
    end else begin
      scan_vld_r <= cmd.scan_rd;
      if (cmd.load) begin
        if (count_r < CNT_MAX) begin
          count_r <= count_r + CNT_W'(1);
          sum_r   <= sum_r + SUM_W'(in_sample);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        count_r <= '0;
        sum_r   <= '0;
        ovf_r   <= 1'b0;
      end
      if (cmd.idx_zero) begin
        sidx_r <= '0;
        vidx_r <= '0;
      end else begin
        if (cmd.h_wr_inc) sidx_r <= sidx_r + ADDR_W'(1);
        if (cmd.clr_wr || cmd.scan_rd) vidx_r <= vidx_r + VW'(1);
      end
      if (cmd.div_init) dcnt_r <= '0;
      else if (cmd.div_step) dcnt_r <= dcnt_r + DC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    vd_r <= vidx_r;
    if (cmd.idx_zero) begin
      seen_r <= '0;
      best_r <= '0;
      mode_r <= '0;
    end else if (scan_vld_r) begin
      seen_r <= seen_nxt;
      if ((seen_r <= ka) && (seen_nxt > ka)) lo_r <= vd_r;
      if ((seen_r <= kb) && (seen_nxt > kb)) hi_r <= vd_r;
      if (hist_rd_r > best_r) begin
        best_r <= hist_rd_r;
        mode_r <= vd_r;
      end
    end
    if (cmd.div_init) begin
      num_r <= NUM_W'({sum_r, 4'b0000}) + NUM_W'({sum_r, 2'b00}) + NUM_W'(count_r);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUM_W-2:0], ge};
      rem_r <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
    end
  end

  assign sts.idx_end  = (vidx_r == mmme_pkg::VAL_MAX);
  assign sts.h_done   = (sidx_r == ADDR_W'(count_r - CNT_W'(1)));
  assign sts.div_last = (dcnt_r == DC_W'(NUM_W - 1));

  assign out_mean_tenths    = (|num_r[NUM_W-1:mmme_pkg::MEAN_W]) ? mmme_pkg::MEAN_SAT
                                                                 : num_r[mmme_pkg::MEAN_W-1:0];
  assign out_median_doubled = mmme_pkg::MEDIAN_W'(lo_r) + mmme_pkg::MEDIAN_W'(hi_r);
  assign out_mode_value     = mode_r;
  assign out_element_count  = mmme_pkg::CNT_OUT_W'(count_r);
  assign out_overflowed     = ovf_r;

endmodule
